>>> design/wbps_pkg.sv
package wbps_pkg;

  localparam int MaxPattern = 32;
  localparam int IdxW = $clog2(MaxPattern);
  localparam int LenW = 6;
  localparam int CountW = 32;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    CmdLoad = 2'd0,
    CmdData = 2'd1,
    CmdEnd  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic       wild;
    logic [7:0] value;
  } entry_t;

  typedef struct packed {
    logic            shift;
    logic            rotate;
    logic            load;
    logic [IdxW-1:0] load_pos;
    logic [LenW-1:0] len;
    entry_t          entry;
  } cell_ctrl_t;

endpackage

>>> design/wbps_if.sv
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] entry_index;
  logic [7:0] entry_byte;
  logic       entry_wild;
  logic [7:0] data_byte;

  modport source(output valid, cmd, entry_index, entry_byte, entry_wild, data_byte,
                 input ready);
  modport sink(input valid, cmd, entry_index, entry_byte, entry_wild, data_byte,
               output ready);
endinterface

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        window_match;
  logic [31:0] match_offset;
  logic [31:0] total_matches;
  logic [31:0] last_offset;
  logic        unique_hit;
  logic        search_done;

  modport source(output valid, window_match, match_offset, total_matches, last_offset,
                 unique_hit, search_done, input ready);
  modport sink(input valid, window_match, match_offset, total_matches, last_offset,
               unique_hit, search_done, output ready);
endinterface

>>> design/wbps_cell.sv
module wbps_cell (
  input  logic                           clk,
  input  wbps_pkg::cell_ctrl_t           ctrl,
  input  logic [wbps_pkg::IdxW-1:0]      cell_idx,
  input  logic [7:0]                     byte_in,
  input  wbps_pkg::entry_t               entry_in,
  output logic [7:0]                     byte_out,
  output wbps_pkg::entry_t               entry_out,
  output logic                           ok
);

  logic [7:0]       byte_q;
  wbps_pkg::entry_t entry_q;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_q <= byte_in;
    end
    if (ctrl.rotate) begin
      entry_q <= entry_in;
    end else if (ctrl.load && (cell_idx == ctrl.load_pos)) begin
      entry_q <= ctrl.entry;
    end
  end

  // cells at or beyond the pattern length always pass
  assign ok = (wbps_pkg::LenW'(cell_idx) >= ctrl.len) || entry_q.wild ||
              (entry_q.value == byte_q);

  assign byte_out  = byte_q;
  assign entry_out = entry_q;

endmodule

>>> design/wildcard_byte_pattern_search_unit.sv
// a result is registered on its item transfer
// throughput: one item per cycle while the ring is aligned; output stall backs up to the input only while full
// after a pattern_length write the pattern ring realigns one position per cycle,
//   with item ready low until it is aligned
// rst (synchronous) clears counters and output valid and sets pattern_length to 1;
//   pattern entries hold no value until loaded
module wildcard_byte_pattern_search_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_wdata,
  wbps_in_if.sink           item,
  wbps_out_if.source        result
);

  localparam int N = wbps_pkg::MaxPattern;

  logic [wbps_pkg::LenW-1:0]   len_q;
  logic [wbps_pkg::LenW-1:0]   eff_len;
  logic [wbps_pkg::IdxW-1:0]   align_q;
  logic [wbps_pkg::CountW-1:0] byte_cnt, byte_cnt_next;
  logic [wbps_pkg::CountW-1:0] match_cnt, match_cnt_next, match_cnt_upd;
  logic [wbps_pkg::CountW-1:0] recent, recent_next, recent_upd;
  logic [wbps_pkg::CountW-1:0] hit_off;
  logic                        aligned, acc, data_go, hit, is_load, is_end, match_all;
  wbps_pkg::cmd_t              cmd;
  wbps_pkg::cell_ctrl_t        ctrl;

  logic [7:0]             byte_chain [N];
  wbps_pkg::entry_t       entry_ring [N];
  logic [N-1:0]           ok_vec;

  always_comb begin
    if (len_q == '0) begin
      eff_len = wbps_pkg::LenW'(1);
    end else if (len_q > wbps_pkg::LenW'(N)) begin
      eff_len = wbps_pkg::LenW'(N);
    end else begin
      eff_len = len_q;
    end
  end

  assign aligned    = (align_q == eff_len[wbps_pkg::IdxW-1:0]);
  assign item.ready = aligned && (!result.valid || result.ready);
  assign acc        = item.valid && item.ready;
  assign cmd        = wbps_pkg::cmd_t'(item.cmd);

  always_comb begin
    is_load = 1'b0;
    is_end  = 1'b0;
    case (cmd)
      wbps_pkg::CmdLoad: is_load = acc;
      wbps_pkg::CmdData: is_load = 1'b0;
      wbps_pkg::CmdEnd:  is_end  = acc;
      default:           is_load = 1'b0;
    endcase
  end

  assign data_go = acc && (cmd == wbps_pkg::CmdData) && (byte_cnt != wbps_pkg::CountMax);

  assign ctrl.shift       = data_go;
  assign ctrl.rotate      = !aligned;
  assign ctrl.load        = is_load;
  assign ctrl.load_pos    = align_q - wbps_pkg::IdxW'(1) - item.entry_index;
  assign ctrl.len         = eff_len;
  assign ctrl.entry.wild  = item.entry_wild;
  assign ctrl.entry.value = item.entry_byte;

  for (genvar k = 0; k < N; k++) begin : g_cell
    wbps_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (wbps_pkg::IdxW'(k)),
      .byte_in   ((k == 0) ? item.data_byte : byte_chain[(k + N - 1) % N]),
      .entry_in  (entry_ring[(k + N - 1) % N]),
      .byte_out  (byte_chain[k]),
      .entry_out (entry_ring[k]),
      .ok        (ok_vec[k])
    );
  end

  assign match_all = &ok_vec;
  assign hit       = data_go && (byte_cnt >= wbps_pkg::CountW'(eff_len)) && match_all;
  assign hit_off   = byte_cnt - wbps_pkg::CountW'(eff_len);

  always_comb begin
    match_cnt_upd = match_cnt;
    recent_upd    = recent;
    if (hit) begin
      recent_upd = hit_off;
      if (match_cnt != wbps_pkg::CountMax) begin
        match_cnt_upd = match_cnt + wbps_pkg::CountW'(1);
      end
    end
    byte_cnt_next  = data_go ? byte_cnt + wbps_pkg::CountW'(1) : byte_cnt;
    match_cnt_next = match_cnt_upd;
    recent_next    = recent_upd;
    if (is_end) begin
      byte_cnt_next  = '0;
      match_cnt_next = '0;
      recent_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_q        <= wbps_pkg::LenW'(1);
      align_q      <= wbps_pkg::IdxW'(1);
      byte_cnt     <= '0;
      match_cnt    <= '0;
      recent       <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_q <= cfg_wdata;
      end
      if (!aligned) begin
        align_q <= align_q + wbps_pkg::IdxW'(1);
      end
      byte_cnt  <= byte_cnt_next;
      match_cnt <= match_cnt_next;
      recent    <= recent_next;
      if (acc) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // result payload on each input transfer
  always_ff @(posedge clk) begin
    if (acc) begin
      result.window_match  <= hit;
      result.match_offset  <= hit ? hit_off : '0;
      result.total_matches <= match_cnt_upd;
      result.last_offset   <= recent_upd;
      result.unique_hit    <= is_end && (match_cnt == wbps_pkg::CountW'(1));
      result.search_done   <= is_end;
    end
  end

endmodule

>>> design/wbps_checker.sv
module wbps_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        window_match,
  input logic [31:0] match_offset,
  input logic [31:0] total_matches,
  input logic [31:0] last_offset,
  input logic        unique_hit,
  input logic        search_done
);

  // stalled result stays valid and holds its match offset and total
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(match_offset) && $stable(total_matches))
    else $error("result changed while stalled");

  a_end_no_match: assert property (@(posedge clk) disable iff (rst)
    valid && search_done |-> !window_match && (match_offset == 32'd0))
    else $error("end result carries a window match");

  a_hit_offset: assert property (@(posedge clk) disable iff (rst)
    valid && window_match |-> (last_offset == match_offset) && (total_matches != 32'd0))
    else $error("match offset not recorded as most recent");

  a_unique: assert property (@(posedge clk) disable iff (rst)
    valid && unique_hit |-> search_done && (total_matches == 32'd1))
    else $error("unique hit without exactly one match");

endmodule

bind wildcard_byte_pattern_search_unit wbps_checker u_wbps_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result.valid),
  .ready         (result.ready),
  .window_match  (result.window_match),
  .match_offset  (result.match_offset),
  .total_matches (result.total_matches),
  .last_offset   (result.last_offset),
  .unique_hit    (result.unique_hit),
  .search_done   (result.search_done)
);

>>> tb/wildcard_byte_pattern_search_unit_test.sv
`timescale 1ns / 100ps

module wildcard_byte_pattern_search_unit_test;

  localparam int ClkHalf = 5;
  localparam int ResetCycles = 6;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 60;
  localparam int SettleCycles = 4;
  localparam int PhaseItems = 70;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int StyleMixed = 0;
  localparam int StyleTrailing = 1;
  localparam int StyleAllWild = 2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] idx;
    logic [7:0] ebyte;
    logic       ewild;
    logic [7:0] dbyte;
  } item_t;

  typedef struct packed {
    logic                        window_match;
    logic [wbps_pkg::CountW-1:0] match_offset;
    logic [wbps_pkg::CountW-1:0] total_matches;
    logic [wbps_pkg::CountW-1:0] last_offset;
    logic                        unique_hit;
    logic                        search_done;
  } match_result_t;

  class search_tracker;
    wbps_pkg::entry_t pattern [wbps_pkg::MaxPattern];
    logic [7:0] window [wbps_pkg::MaxPattern + 1];
    logic [wbps_pkg::CountW-1:0] byte_count;
    logic [wbps_pkg::CountW-1:0] match_count;
    logic [wbps_pkg::CountW-1:0] recent;
    logic [wbps_pkg::LenW-1:0] length_reg;
    match_result_t pending_results [$];
    int errors;

    function new();
      foreach (pattern[k]) pattern[k] = '0;
      length_reg = wbps_pkg::LenW'(1);
      errors = 0;
      clear_search();
    endfunction

    function void clear_search();
      foreach (window[k]) window[k] = 8'h00;
      byte_count = '0;
      match_count = '0;
      recent = '0;
    endfunction

    function void set_length(input logic [wbps_pkg::LenW-1:0] v);
      length_reg = v;
    endfunction

    function int active_length();
      if (length_reg == 0) return 1;
      if (length_reg > wbps_pkg::MaxPattern) return wbps_pkg::MaxPattern;
      return int'(length_reg);
    endfunction

    // trailing wild entries are skipped, entry 0 is never skipped
    function bit window_hit(input int len);
      int last;
      last = len - 1;
      while (last > 0 && pattern[last].wild) last--;
      for (int j = 0; j <= last; j++)
        if (!pattern[j].wild && pattern[j].value != window[len - j]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_item(input item_t it);
      match_result_t r;
      int len;
      r = '0;
      len = active_length();
      case (it.cmd)
        wbps_pkg::CmdLoad: pattern[it.idx] = {it.ewild, it.ebyte};
        wbps_pkg::CmdData: begin
          if (byte_count != wbps_pkg::CountMax) begin
            for (int k = wbps_pkg::MaxPattern; k > 0; k--) window[k] = window[k - 1];
            window[0] = it.dbyte;
            byte_count++;
            if (byte_count > len && window_hit(len)) begin
              r.window_match = 1'b1;
              r.match_offset = byte_count - 1 - len;
              recent = r.match_offset;
              if (match_count != wbps_pkg::CountMax) match_count++;
            end
          end
        end
        default: ;
      endcase
      r.total_matches = match_count;
      r.last_offset = recent;
      if (it.cmd == wbps_pkg::CmdEnd) begin
        r.search_done = 1'b1;
        r.unique_hit = (match_count == 1);
        clear_search();
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(input match_result_t got);
      match_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("error: result transfer with nothing pending");
        return;
      end
      want = pending_results.pop_front();
      if (got.window_match !== want.window_match || got.match_offset !== want.match_offset ||
          got.total_matches !== want.total_matches || got.last_offset !== want.last_offset ||
          got.unique_hit !== want.unique_hit || got.search_done !== want.search_done) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected match %0b offset %0d total %0d last %0d unique %0b done %0b",
                   want.window_match, want.match_offset, want.total_matches,
                   want.last_offset, want.unique_hit, want.search_done);
          $display("          actual   match %0b offset %0d total %0d last %0d unique %0b done %0b",
                   got.window_match, got.match_offset, got.total_matches,
                   got.last_offset, got.unique_hit, got.search_done);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [5:0] cfg_wdata;
  wbps_in_if item_ch();
  wbps_out_if result_ch();

  search_tracker tracker;
  logic [7:0] pat_val [wbps_pkg::MaxPattern];
  logic pat_wild [wbps_pkg::MaxPattern];
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm;
  bit hold_req;

  wildcard_byte_pattern_search_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .item(item_ch),
    .result(result_ch)
  );

  always #ClkHalf clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0, 1: return pat_val[$urandom_range(0, wbps_pkg::MaxPattern - 1)];
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic item_t fresh_item(input logic [1:0] op);
    item_t it;
    it.cmd = op;
    it.idx = 5'($urandom);
    it.ebyte = 8'($urandom);
    it.ewild = 1'($urandom);
    it.dbyte = 8'($urandom);
    return it;
  endfunction

  task automatic push_item(input item_t it);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.cmd <= it.cmd;
    item_ch.entry_index <= it.idx;
    item_ch.entry_byte <= it.ebyte;
    item_ch.entry_wild <= it.ewild;
    item_ch.data_byte <= it.dbyte;
    do @(posedge clk); while (!item_ch.ready);
    tracker.note_item(it);
    items_sent++;
  endtask

  task automatic send_load(input logic [4:0] idx, input logic [7:0] b, input logic w);
    item_t it;
    it = fresh_item(wbps_pkg::CmdLoad);
    it.idx = idx;
    it.ebyte = b;
    it.ewild = w;
    push_item(it);
    pat_val[idx] = b;
    pat_wild[idx] = w;
  endtask

  task automatic send_data(input logic [7:0] b);
    item_t it;
    it = fresh_item(wbps_pkg::CmdData);
    it.dbyte = b;
    push_item(it);
  endtask

  task automatic send_end();
    push_item(fresh_item(wbps_pkg::CmdEnd));
  endtask

  task automatic send_unused();
    push_item(fresh_item(CmdUnused));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_length(input logic [5:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_length(v);
  endtask

  task automatic load_pattern(input int style);
    int len;
    int tail;
    logic w;
    logic [7:0] b;
    len = tracker.active_length();
    tail = (len > 1) ? $urandom_range(1, len - 1) : wbps_pkg::MaxPattern;
    for (int k = 0; k < wbps_pkg::MaxPattern; k++) begin
      case ($urandom_range(0, 3))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      if (style == StyleAllWild) w = 1'b1;
      else if (style == StyleTrailing && k >= tail) w = 1'b1;
      else w = ($urandom_range(0, 4) == 0);
      send_load(5'(k), b, w);
    end
  endtask

  // one copy of the pattern, sometimes with one bit flipped
  task automatic send_copy(input int len);
    int spoil;
    logic [7:0] b;
    spoil = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int j = 0; j < len; j++) begin
      b = pat_wild[j] ? pick_byte() : pat_val[j];
      if (j == spoil) b = b ^ 8'(1 << $urandom_range(0, 7));
      send_data(b);
    end
  endtask

  task automatic send_image();
    int len;
    int nbytes;
    int sent;
    int r;
    len = tracker.active_length();
    if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, len);
    else nbytes = $urandom_range(len, 3 * len + 20);
    sent = 0;
    while (sent < nbytes) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_copy(len);
        sent += len;
      end else if (r < 38) begin
        send_load(5'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 41) begin
        send_unused();
      end else begin
        send_data(pick_byte());
        sent++;
      end
    end
    send_end();
  endtask

  initial begin
    int stall;
    stall = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (stall == 0 && !calm) stall = pick_gap();
        result_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_result({result_ch.window_match, result_ch.match_offset,
                            result_ch.total_matches, result_ch.last_offset,
                            result_ch.unique_hit, result_ch.search_done});
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL wildcard_byte_pattern_search_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [5:0] lengths [12];
    int styles [12];
    int phase_start;
    tracker = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.cmd = '0;
    item_ch.entry_index = '0;
    item_ch.entry_byte = '0;
    item_ch.entry_wild = 1'b0;
    item_ch.data_byte = '0;
    result_ch.ready = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    foreach (pat_val[k]) begin
      pat_val[k] = 8'h00;
      pat_wild[k] = 1'b0;
    end
    lengths = '{6'd32, 6'd0, 6'd63, 6'd33, 6'd1, 6'd2, 6'd3, 6'd8, 6'd31, 6'd16,
                6'($urandom), 6'($urandom)};
    styles = '{StyleMixed, StyleMixed, StyleTrailing, StyleMixed, StyleAllWild,
               StyleTrailing, StyleMixed, StyleTrailing, StyleMixed, StyleAllWild,
               StyleMixed, StyleTrailing};
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // length 1 from reset: short images, too few bytes, reload mid image
    send_load(5'd0, 8'hFF, 1'b0);
    send_load(5'd31, 8'h00, 1'b1);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hFF);
    send_unused();
    send_data(8'h00);
    send_load(5'd0, 8'h00, 1'b0);
    send_data(8'h00);
    send_end();
    send_load(5'd0, 8'h5A, 1'b0);
    send_data(8'h5A);
    send_data(8'h00);
    send_end();
    send_load(5'd0, 8'h00, 1'b1);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'h33);
    send_end();
    send_end();

    foreach (lengths[ph]) begin
      write_length(lengths[ph]);
      load_pattern(styles[ph]);
      calm = (ph == 5 || ph == 9);
      if (ph == 3) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) send_image();
      calm = 1'b0;
    end

    wait_idle();
    if (tracker.errors == 0 && tracker.pending_results.size() == 0)
      $display("PASS wildcard_byte_pattern_search_unit");
    else
      $display("FAIL wildcard_byte_pattern_search_unit");
    $finish;
  end

endmodule
